// ===== hdl/integer_to_ascii_digits_assert.svh =====
// Assertion macros shared by the RTL files.
`ifndef INTEGER_TO_ASCII_DIGITS_ASSERT_SVH
`define INTEGER_TO_ASCII_DIGITS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITAD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ITAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/itad_pkg.sv =====
package itad_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_W = 4 * NUM_DIGITS;
    localparam int LEFT_W = $clog2(NUM_DIGITS + 1);
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    localparam logic [1:0] CMD_UNSIGNED = 2'd0;
    localparam logic [1:0] CMD_SIGNED = 2'd1;
    localparam logic [1:0] CMD_HEX = 2'd2;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_LETTER_BASE = 8'h37;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SUFFIX = 8'h48;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] value;
    } t_item;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_STRIP,
        ST_SIGN,
        ST_EMIT,
        ST_SUFFIX
    } t_state;

    typedef enum logic [1:0] {
        EMIT_DIGIT,
        EMIT_MINUS,
        EMIT_SUFFIX
    } t_emit_kind;

    typedef struct packed {
        logic       load;
        logic       dabble;
        logic       strip;
        logic       emit;
        t_emit_kind kind;
    } t_ctrl_cmd;

    typedef struct packed {
        logic top_zero;
        logic left_one;
        logic hex;
        logic neg;
    } t_dp_status;

    function automatic logic [7:0] glyph(input logic [3:0] digit);
        if (digit < 4'd10) begin
            return CHAR_ZERO + {4'h0, digit};
        end else begin
            return CHAR_LETTER_BASE + {4'h0, digit};
        end
    endfunction

endpackage

// ===== hdl/itad_ctrl.sv =====
module itad_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_hex_request,
    input  itad_pkg::t_dp_status  i_status,
    output itad_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_busy
);
    import itad_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        o_cmd = '{load: 1'b0, dabble: 1'b0, strip: 1'b0, emit: 1'b0, kind: EMIT_DIGIT};
        o_busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_count = '0;
                    n_state = i_hex_request ? ST_STRIP : ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                o_cmd.dabble = 1'b1;
                n_count = r_count + 1'b1;
                if (r_count == CNT_W'(VALUE_WIDTH - 1)) begin
                    n_state = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (i_status.top_zero && !i_status.left_one) begin
                    o_cmd.strip = 1'b1;
                end else begin
                    n_state = i_status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EMIT_MINUS;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EMIT_DIGIT;
                if (i_status.left_one) begin
                    n_state = i_status.hex ? ST_SUFFIX : ST_IDLE;
                end
            end
            ST_SUFFIX: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = EMIT_SUFFIX;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`include "integer_to_ascii_digits_assert.svh"

    `ITAD_ASSERT_NEXT(a_convert_exit, i_clk, i_rst_n, r_state == ST_CONVERT, r_state == ST_CONVERT || r_state == ST_STRIP)
    `ITAD_ASSERT_SAME(a_strip_not_hex_sign, i_clk, i_rst_n, r_state == ST_SIGN, !i_status.hex)

endmodule

// ===== hdl/itad_datapath.sv =====
module itad_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  itad_pkg::t_item       i_item,
    input  itad_pkg::t_ctrl_cmd   i_cmd,
    output itad_pkg::t_dp_status  o_status,
    output logic                  o_strobe,
    output itad_pkg::t_result     o_result
);
    import itad_pkg::*;

    logic [DIG_W-1:0]        r_dig;
    logic [DIG_W-1:0]        n_dig;
    logic [VALUE_WIDTH-1:0]  r_bin;
    logic [VALUE_WIDTH-1:0]  n_bin;
    logic [LEFT_W-1:0]       r_left;
    logic [LEFT_W-1:0]       n_left;
    logic                    r_hex;
    logic                    r_neg;
    logic                    r_strobe;
    logic [7:0]              r_char;
    logic                    r_last;

    logic [VALUE_WIDTH-1:0]  in_val;
    logic [VALUE_WIDTH-1:0]  in_mag;
    logic                    in_hex;
    logic                    in_neg;
    logic [DIG_W-1:0]        adj;
    logic [3:0]              top;
    logic [7:0]              emit_char;
    logic                    emit_last;

    // Command bit 1 selects hexadecimal, so the unused code also prints in hexadecimal.
    assign in_hex = i_item.command[1];
    assign in_val = i_item.value[VALUE_WIDTH-1:0];
    assign in_neg = (i_item.command == CMD_SIGNED) && in_val[VALUE_WIDTH-1];
    assign in_mag = in_neg ? (~in_val + 1'b1) : in_val;
    assign top = r_dig[DIG_W-1 -: 4];

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[4*i +: 4] = (r_dig[4*i +: 4] >= 4'd5) ? (r_dig[4*i +: 4] + 4'd3)
                                                      : r_dig[4*i +: 4];
        end
    end

    always_comb begin
        n_dig = r_dig;
        n_bin = r_bin;
        n_left = r_left;
        if (i_cmd.load) begin
            n_dig = in_hex ? DIG_W'(in_mag) : '0;
            n_bin = in_mag;
            n_left = LEFT_W'(NUM_DIGITS);
        end else if (i_cmd.dabble) begin
            n_dig = {adj[DIG_W-2:0], r_bin[VALUE_WIDTH-1]};
            n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
        end else if (i_cmd.strip || (i_cmd.emit && i_cmd.kind == EMIT_DIGIT)) begin
            n_dig = {r_dig[DIG_W-5:0], 4'h0};
            n_left = r_left - 1'b1;
        end
    end

    always_comb begin
        emit_char = glyph(top);
        emit_last = 1'b0;
        unique case (i_cmd.kind)
            EMIT_DIGIT: begin
                emit_char = glyph(top);
                emit_last = (r_left == LEFT_W'(1)) && !r_hex;
            end
            EMIT_MINUS: begin
                emit_char = CHAR_MINUS;
            end
            EMIT_SUFFIX: begin
                emit_char = CHAR_SUFFIX;
                emit_last = 1'b1;
            end
            default: begin
                emit_char = glyph(top);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_dig <= n_dig;
        r_bin <= n_bin;
        r_left <= n_left;
        if (i_cmd.load) begin
            r_hex <= in_hex;
            r_neg <= in_neg;
        end
        if (i_cmd.emit) begin
            r_char <= emit_char;
            r_last <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    assign o_status = '{top_zero: (top == 4'h0), left_one: (r_left == LEFT_W'(1)),
                        hex: r_hex, neg: r_neg};
    assign o_strobe = r_strobe;
    assign o_result = '{character: r_char, last: r_last};

`include "integer_to_ascii_digits_assert.svh"

    `ITAD_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, r_strobe && r_last, !r_strobe)
    `ITAD_ASSERT_SAME(a_digit_left, i_clk, i_rst_n, i_cmd.emit && i_cmd.kind == EMIT_DIGIT, r_left != '0)

endmodule

// ===== hdl/integer_to_ascii_digits.sv =====
// Channel   Ports                        Transfer
// input     start, busy, i_item          start high while busy is low
// result    o_strobe, o_result           o_strobe high for one cycle per character
//
// Decimal items are loaded, run a double-dabble step for each value bit, drop leading zero
// digits one at a time, then emit their characters, a minus sign first if negative.
// Hexadecimal items skip the double-dabble pass.
// Reset is synchronous and active low; it returns the controller to idle.
// Results cannot be stalled; busy stays high until the last character is issued.
module integer_to_ascii_digits (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  itad_pkg::t_item    i_item,
    output logic               busy,
    output logic               o_strobe,
    output itad_pkg::t_result  o_result
);
    import itad_pkg::*;

    t_ctrl_cmd   cmd;
    t_dp_status  status;

    itad_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_hex_request (i_item.command[1]),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_busy        (busy)
    );

    itad_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import itad_pkg::*;

    localparam logic [1:0] CMD_HEX_ALIAS = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 44;

    class ascii_text_board;
        t_result pending_chars[$];
        int errors = 0;

        function void add_number(t_item it);
            logic [63:0] mask;
            logic [63:0] mag;
            logic [63:0] radix;
            logic [63:0] rem;
            logic [7:0] digits[$];
            logic hex;
            logic neg;
            t_result r;
            mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
            mag = it.value & mask;
            hex = it.command[1];
            neg = 1'b0;
            if (!hex && it.command[0] && mag[VALUE_WIDTH-1]) begin
                neg = 1'b1;
                mag = (-mag) & mask;
            end
            radix = hex ? 64'd16 : 64'd10;
            do begin
                rem = mag % radix;
                if (rem < 10) begin
                    digits.push_front(CHAR_ZERO + rem[7:0]);
                end else begin
                    digits.push_front(8'h41 + rem[7:0] - 8'd10);
                end
                mag = mag / radix;
            end while (mag != 0);
            if (neg) begin
                r.character = CHAR_MINUS;
                r.last = 1'b0;
                pending_chars.push_back(r);
            end
            foreach (digits[i]) begin
                r.character = digits[i];
                r.last = !hex && (i == digits.size() - 1);
                pending_chars.push_back(r);
            end
            if (hex) begin
                r.character = CHAR_SUFFIX;
                r.last = 1'b1;
                pending_chars.push_back(r);
            end
        endfunction

        function void check_char(t_result got);
            t_result want;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character %h last %b", $time,
                         got.character, got.last);
                errors++;
            end else begin
                want = pending_chars.pop_front();
                if (got.character !== want.character) begin
                    $display("%0t: character mismatch, expected %h, actual %h", $time,
                             want.character, got.character);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last flag mismatch, expected %b, actual %b", $time,
                             want.last, got.last);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_item i_item;
    logic busy;
    logic o_strobe;
    t_result o_result;

    ascii_text_board board;
    int idle_pct;
    int cycle_count;

    integer_to_ascii_digits DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_strobe === 1'b1) begin
                board.check_char(o_result);
            end
            if (start === 1'b1 && busy === 1'b0) begin
                board.add_number(i_item);
            end
        end
    end

    task automatic send_number(input logic [1:0] cmd, input logic [63:0] val);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item.command <= cmd;
        i_item.value <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    initial begin
        int phase_idle[3];
        logic [63:0] val;
        logic [63:0] pow;
        logic [1:0] cmd;
        int k;
        board = new();
        phase_idle = '{0, 88, 8};
        idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_number(CMD_UNSIGNED, 64'd0);
        send_number(CMD_UNSIGNED, 64'd9);
        send_number(CMD_UNSIGNED, 64'd10);
        send_number(CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(CMD_UNSIGNED, 64'd10000000000000000000);
        send_number(CMD_UNSIGNED, 64'd9999999999999999999);
        send_number(CMD_SIGNED, 64'd0);
        send_number(CMD_SIGNED, 64'd1);
        send_number(CMD_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(CMD_SIGNED, 64'h8000_0000_0000_0000);
        send_number(CMD_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
        send_number(CMD_SIGNED, 64'hFFFF_FFFF_FFFF_FFF6);
        send_number(CMD_HEX, 64'd0);
        send_number(CMD_HEX, 64'hF);
        send_number(CMD_HEX, 64'h0123_4567_89AB_CDEF);
        send_number(CMD_HEX, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(CMD_HEX, 64'hFEDC_BA98_7654_3210);
        send_number(CMD_HEX_ALIAS, 64'h1A);
        send_number(CMD_HEX_ALIAS, 64'hFFFF_FFFF_FFFF_FFFF);

        foreach (phase_idle[p]) begin
            idle_pct = phase_idle[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: cmd = CMD_UNSIGNED;
                    3, 4, 5: cmd = CMD_SIGNED;
                    6, 7, 8: cmd = CMD_HEX;
                    default: cmd = CMD_HEX_ALIAS;
                endcase
                case ($urandom_range(0, 4))
                    0: val = {$urandom, $urandom};
                    1: val = 64'($urandom_range(0, 1000));
                    2: begin
                        pow = 64'd1;
                        k = $urandom_range(0, 19);
                        repeat (k) pow = pow * 64'd10;
                        val = pow + 64'($urandom_range(0, 2)) - 64'd1;
                    end
                    3: val = -{32'h0, $urandom_range(1, 1000)};
                    default: begin
                        val = 64'd1 << $urandom_range(0, 63);
                        if ($urandom_range(0, 1) == 1) begin
                            val = val - 64'd1;
                        end
                    end
                endcase
                send_number(cmd, val);
            end
        end
        start <= 1'b0;

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
